@@ rtl/windowed_peak_rms_meter_defines.svh @@
// Assertion macros for the windowed peak and RMS meter.
`ifndef WINDOWED_PEAK_RMS_METER_DEFINES_SVH
`define WINDOWED_PEAK_RMS_METER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WPRM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WPRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wprm_pkg.sv @@
// Shared types and constants of the windowed peak and RMS meter.
`timescale 1ns / 1ps

package wprm_pkg;

	localparam int SAMPLE_W   = 22;
	localparam int POS_W      = 10;
	localparam int LEN_W      = 11;
	localparam int SCALED_W   = 13;
	localparam int SQUARE_W   = 26;
	localparam int TOTAL_W    = 35;
	localparam int RECIP_W    = 23;
	localparam int PROD_W     = SAMPLE_W + RECIP_W;
	localparam int RECIP_SHIFT = 32;
	localparam int RAD_W      = 36;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int RMS_W      = 13;
	localparam int STEP_W     = 6;

	localparam logic [LEN_W-1:0]   LENGTH_RESET = 11'd500;
	localparam logic [LEN_W-1:0]   MAX_WINDOW   = 11'd1024;
	// ceil(2^32 / 1000); exact floor(s / 1000) for every 22-bit s
	localparam logic [RECIP_W-1:0] RECIP_1000   = 23'd4294968;

	localparam logic [STEP_W-1:0] DIV_LAST  = 6'(TOTAL_W - 1);
	localparam logic [STEP_W-1:0] ROOT_LAST = 6'(ROOT_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SQUARE,
		ST_ACCUM,
		ST_DIVIDE,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_PUBLISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic scale;
		logic square;
		logic accum;
		logic div_step;
		logic root_init;
		logic root_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic window_done;
		logic out_busy;
	} ctrl_status_t;

endpackage

@@ rtl/wprm_ctrl.sv @@
// Sequencer of the meter: steps each sample and the end-of-window divide and root.
`timescale 1ns / 1ps

module wprm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  wprm_pkg::ctrl_status_t status,
	output wprm_pkg::ctrl_cmd_t   cmd
);

	wprm_pkg::state_t state_q, state_d;
	logic [wprm_pkg::STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wprm_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				step_q <= '0;
			else
				step_q <= step_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wprm_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = wprm_pkg::ST_SCALE;
			end
			wprm_pkg::ST_SCALE:  state_d = wprm_pkg::ST_SQUARE;
			wprm_pkg::ST_SQUARE: state_d = wprm_pkg::ST_ACCUM;
			wprm_pkg::ST_ACCUM: begin
				state_d = status.window_done ? wprm_pkg::ST_DIVIDE : wprm_pkg::ST_IDLE;
			end
			wprm_pkg::ST_DIVIDE: begin
				if (step_q == wprm_pkg::DIV_LAST)
					state_d = wprm_pkg::ST_ROOT_INIT;
			end
			wprm_pkg::ST_ROOT_INIT: state_d = wprm_pkg::ST_ROOT;
			wprm_pkg::ST_ROOT: begin
				if (step_q == wprm_pkg::ROOT_LAST)
					state_d = wprm_pkg::ST_PUBLISH;
			end
			wprm_pkg::ST_PUBLISH: begin
				if (!status.out_busy)
					state_d = wprm_pkg::ST_IDLE;
			end
			default: state_d = wprm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			wprm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			wprm_pkg::ST_SCALE:     cmd.scale     = 1'b1;
			wprm_pkg::ST_SQUARE:    cmd.square    = 1'b1;
			wprm_pkg::ST_ACCUM:     cmd.accum     = 1'b1;
			wprm_pkg::ST_DIVIDE:    cmd.div_step  = 1'b1;
			wprm_pkg::ST_ROOT_INIT: cmd.root_init = 1'b1;
			wprm_pkg::ST_ROOT:      cmd.root_step = 1'b1;
			wprm_pkg::ST_PUBLISH:   cmd.out_load  = !status.out_busy;
			default: ;
		endcase
	end

endmodule

@@ rtl/wprm_datapath.sv @@
// Datapath of the meter: window tracking, square sum, serial divider and root, result register.
`timescale 1ns / 1ps

module wprm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wprm_pkg::LEN_W-1:0]    cfg_data,
	input  logic [wprm_pkg::SAMPLE_W-1:0] sample,
	input  wprm_pkg::ctrl_cmd_t           cmd,
	output wprm_pkg::ctrl_status_t        status,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [wprm_pkg::SAMPLE_W-1:0] peak_to_peak,
	output logic [wprm_pkg::POS_W-1:0]    extreme_distance,
	output logic [wprm_pkg::RMS_W-1:0]    rms_value
);

	localparam int SW = wprm_pkg::SAMPLE_W;
	localparam int PW = wprm_pkg::POS_W;
	localparam int LW = wprm_pkg::LEN_W;
	localparam int TW = wprm_pkg::TOTAL_W;
	localparam int RW = wprm_pkg::RAD_W;
	localparam int QW = wprm_pkg::ROOT_W;
	localparam int MW = wprm_pkg::REM_W;

	logic [LW-1:0] window_length_q;
	logic [PW-1:0] pos_q;
	logic          done_q;
	logic [TW-1:0] total_q;
	logic          out_valid_q;

	logic [SW-1:0] sample_q, lowest_q, highest_q;
	logic [PW-1:0] lowest_pos_q, highest_pos_q;
	logic [wprm_pkg::PROD_W-1:0]   prod_q;
	logic [wprm_pkg::SQUARE_W-1:0] square_q;
	logic [TW-1:0] quot_q;
	logic [LW-1:0] div_rem_q, divisor_q;
	logic [RW-1:0] rad_q;
	logic [MW-1:0] root_rem_q;
	logic [QW-1:0] root_q;
	logic [SW-1:0] p2p_q;
	logic [PW-1:0] dist_q;
	logic [wprm_pkg::RMS_W-1:0] rms_q;

	logic [LW-1:0]   len_eff;
	logic [LW-1:0]   count;
	logic            closes;
	logic [wprm_pkg::SCALED_W-1:0] scaled;
	logic [TW-1:0]   sum;
	logic [LW:0]     div_trial;
	logic            div_ge;
	logic [MW+1:0]   root_trial_rem;
	logic [MW+1:0]   root_trial;
	logic            root_ge;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (window_length_q == '0)
			len_eff = LW'(1);
		else if (window_length_q > wprm_pkg::MAX_WINDOW)
			len_eff = wprm_pkg::MAX_WINDOW;
		else
			len_eff = window_length_q;
	end

	assign count  = {1'b0, pos_q} + LW'(1);
	assign closes = count >= len_eff;
	assign scaled = prod_q[wprm_pkg::PROD_W-1:wprm_pkg::RECIP_SHIFT];
	assign sum    = total_q + TW'(square_q);

	// restoring divide, one quotient bit per step
	assign div_trial = {div_rem_q, quot_q[TW-1]};
	assign div_ge    = div_trial >= {1'b0, divisor_q};

	// digit-by-digit root, two radicand bits per step
	assign root_trial_rem = {root_rem_q, rad_q[RW-1 -: 2]};
	assign root_trial     = (MW+2)'({root_q, 2'b01});
	assign root_ge        = root_trial_rem >= root_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= wprm_pkg::LENGTH_RESET;
			pos_q           <= '0;
			done_q          <= 1'b0;
			total_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid)
				window_length_q <= cfg_data;
			if (cmd.accept) begin
				done_q <= closes;
				pos_q  <= closes ? '0 : count[PW-1:0];
			end
			if (cmd.accum)
				total_q <= done_q ? '0 : sum;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			if (pos_q == '0) begin
				lowest_q      <= sample;
				highest_q     <= sample;
				lowest_pos_q  <= '0;
				highest_pos_q <= '0;
			end else begin
				if (sample < lowest_q) begin
					lowest_q     <= sample;
					lowest_pos_q <= pos_q;
				end
				if (sample > highest_q) begin
					highest_q     <= sample;
					highest_pos_q <= pos_q;
				end
			end
		end
		if (cmd.scale)
			prod_q <= wprm_pkg::PROD_W'(sample_q) * wprm_pkg::PROD_W'(wprm_pkg::RECIP_1000);
		if (cmd.square)
			square_q <= wprm_pkg::SQUARE_W'(scaled) * wprm_pkg::SQUARE_W'(scaled);
		if (cmd.accum) begin
			quot_q    <= sum;
			div_rem_q <= '0;
			divisor_q <= len_eff;
		end
		if (cmd.div_step) begin
			quot_q    <= {quot_q[TW-2:0], div_ge};
			div_rem_q <= div_ge ? LW'(div_trial - {1'b0, divisor_q}) : div_trial[LW-1:0];
		end
		if (cmd.root_init) begin
			rad_q      <= RW'(quot_q);
			root_rem_q <= '0;
			root_q     <= '0;
		end
		if (cmd.root_step) begin
			rad_q      <= {rad_q[RW-3:0], 2'b00};
			root_q     <= {root_q[QW-2:0], root_ge};
			root_rem_q <= root_ge ? MW'(root_trial_rem - root_trial) : MW'(root_trial_rem);
		end
		if (cmd.out_load) begin
			p2p_q  <= highest_q - lowest_q;
			dist_q <= (highest_pos_q >= lowest_pos_q) ? highest_pos_q - lowest_pos_q
			                                          : lowest_pos_q - highest_pos_q;
			rms_q  <= root_q[wprm_pkg::RMS_W-1:0];
		end
	end

	assign status.window_done = done_q;
	assign status.out_busy    = out_valid_q;

	assign out_valid        = out_valid_q;
	assign peak_to_peak     = p2p_q;
	assign extreme_distance = dist_q;
	assign rms_value        = rms_q;

endmodule

@@ rtl/windowed_peak_rms_meter.sv @@
// Windowed peak-to-peak and RMS meter, top level.
//
// Each sample beat on s_axis is accepted, scaled to millivolts by reciprocal multiply,
// squared and added into the window sum, all in sequence on one datapath, before the
// next beat is taken. The sample that closes a window holds off the next beat further
// through 35 steps of the bit-serial divide by the window length, a radicand load and
// 18 steps of the two-bit-per-step square root, then the load of the result, and longer
// if the previous result beat is still waiting on m_axis. A finished result sits in an
// output register, so sampling goes on while it waits. The window length is written on
// the cfg channel, always ready; 0 acts as 1 and values above 1024 act as 1024.
`timescale 1ns / 1ps
`include "windowed_peak_rms_meter_defines.svh"

module windowed_peak_rms_meter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,      // window_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [21:0] sample, [23:22] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // [21:0] peak_to_peak, [31:22] extreme_distance,
	                                   // [44:32] rms_value, [47:45] zero
);

	wprm_pkg::ctrl_cmd_t    cmd;
	wprm_pkg::ctrl_status_t status;

	logic [wprm_pkg::SAMPLE_W-1:0] peak_to_peak;
	logic [wprm_pkg::POS_W-1:0]    extreme_distance;
	logic [wprm_pkg::RMS_W-1:0]    rms_value;

	wprm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	wprm_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.sample           (s_axis_tdata[wprm_pkg::SAMPLE_W-1:0]),
		.cmd              (cmd),
		.status           (status),
		.out_ready        (m_axis_tready),
		.out_valid        (m_axis_tvalid),
		.peak_to_peak     (peak_to_peak),
		.extreme_distance (extreme_distance),
		.rms_value        (rms_value)
	);

	assign m_axis_tdata = {3'b000, rms_value, extreme_distance, peak_to_peak};

	`WPRM_ASSERT_NEXT(a_one_sample_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "sample beat taken while previous sample still in work")
	`WPRM_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !m_axis_tvalid, "result register loaded while holding an untaken beat")
	`WPRM_ASSERT_NOW(a_rms_in_range, m_axis_tvalid, m_axis_tdata[44:32] <= 13'd4194, "rms_value above largest millivolt reading")

endmodule

@@ bench/windowed_peak_rms_meter_tb.sv @@
// Self-checking bench for the windowed peak-to-peak and RMS meter.
`timescale 1ns / 1ps

typedef struct packed {
	logic [2:0]  pad;
	logic [12:0] rms;
	logic [9:0]  span;
	logic [21:0] peak;
} meter_reading_t;

class meter_scoreboard;
	meter_reading_t expected_readings[$];
	int unsigned    errors;
	int unsigned    readings_checked;
	int unsigned    samples_noted;
	logic [10:0]    length_reg;
	logic [9:0]     position;
	logic [21:0]    lowest;
	logic [21:0]    highest;
	logic [9:0]     low_pos;
	logic [9:0]     high_pos;
	logic [34:0]    square_sum;

	function new();
		length_reg = wprm_pkg::LENGTH_RESET;
		clear_window();
	endfunction

	function void clear_window();
		position   = '0;
		lowest     = '1;
		highest    = '0;
		low_pos    = '0;
		high_pos   = '0;
		square_sum = '0;
	endfunction

	function void set_length(logic [10:0] v);
		length_reg = v;
	endfunction

	function int unsigned pending();
		return expected_readings.size();
	endfunction

	function logic [17:0] floor_root(logic [34:0] v);
		logic [17:0] r;
		logic [17:0] t;
		r = '0;
		for (int b = 17; b >= 0; b--) begin
			t = r | (18'd1 << b);
			if (36'(t) * 36'(t) <= 36'(v))
				r = t;
		end
		return r;
	endfunction

	// Advance the window by one sample; queue a reading when it closes.
	function void note_sample(logic [21:0] s);
		int unsigned    eff;
		int unsigned    count;
		logic [12:0]    mv;
		meter_reading_t r;
		eff = length_reg;
		if (eff < 1)
			eff = 1;
		if (eff > wprm_pkg::MAX_WINDOW)
			eff = wprm_pkg::MAX_WINDOW;
		samples_noted++;
		if (position == 0) begin
			lowest   = s;
			highest  = s;
			low_pos  = '0;
			high_pos = '0;
		end else begin
			if (s < lowest) begin
				lowest  = s;
				low_pos = position;
			end
			if (s > highest) begin
				highest  = s;
				high_pos = position;
			end
		end
		mv = 13'(s / 1000);
		square_sum += 35'(mv) * 35'(mv);
		count = position;
		count = count + 1;
		if (count < eff) begin
			position = position + 1'b1;
			return;
		end
		r.pad  = '0;
		r.peak = highest - lowest;
		r.span = (high_pos >= low_pos) ? high_pos - low_pos : low_pos - high_pos;
		r.rms  = 13'(floor_root(35'(square_sum / eff)));
		expected_readings.push_back(r);
		clear_window();
	endfunction

	task report(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task check_reading(logic [47:0] d);
		meter_reading_t want;
		if (expected_readings.size() == 0) begin
			report($sformatf("result beat with none pending, tdata %h", d));
			return;
		end
		want = expected_readings.pop_front();
		readings_checked++;
		if (d[21:0] != want.peak)
			report($sformatf("peak_to_peak exp %0d got %0d", want.peak, d[21:0]));
		if (d[31:22] != want.span)
			report($sformatf("extreme_distance exp %0d got %0d", want.span, d[31:22]));
		if (d[44:32] != want.rms)
			report($sformatf("rms_value exp %0d got %0d", want.rms, d[44:32]));
		if (d[47:45] != want.pad)
			report($sformatf("tdata padding not zero: %b", d[47:45]));
	endtask
endclass

module windowed_peak_rms_meter_tb;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [wprm_pkg::LEN_W-1:0]   cfg_data = '0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [23:0]                  s_axis_tdata = '0;   // [21:0] sample, [23:22] zero
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [47:0]                  m_axis_tdata;        // [21:0] peak_to_peak,
	                                                   // [31:22] extreme_distance,
	                                                   // [44:32] rms_value, [47:45] zero

	meter_scoreboard board;
	logic            idling_on = 1'b1;
	int unsigned     settings_used;
	int unsigned     directed_count;
	int unsigned     phase;
	int unsigned     burst_len;
	logic [wprm_pkg::LEN_W-1:0] next_length;

	windowed_peak_rms_meter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("FAIL");
		$finish;
	end

	// Result side: check accepted beats, stall at random while idling is on.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_reading(m_axis_tdata);
		m_axis_tready <= !idling_on || ($urandom_range(0, 99) >= 20);
	end

	function automatic logic [wprm_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return wprm_pkg::SAMPLE_W'($urandom_range(0, 3) * 1000);  // ties
			3:       return wprm_pkg::SAMPLE_W'($urandom_range(995, 1005));     // mV edge
			default: return wprm_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task write_length(input logic [wprm_pkg::LEN_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_length(v);
		settings_used++;
		cfg_valid <= 1'b0;
	endtask

	task send_sample(input logic [wprm_pkg::SAMPLE_W-1:0] v);
		if (idling_on && $urandom_range(0, 99) < 20) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, v};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_sample(v);
	endtask

	// Stop sending, wait for every pending reading, then let the datapath settle.
	task drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
	endtask

	initial begin
		board = new();
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length, then shrink mid-window so the next sample closes it
		send_sample(22'd0);
		send_sample(22'h3FFFFF);
		send_sample(22'd999);
		send_sample(22'd1000);
		drain();
		write_length(11'd1);
		send_sample(22'd1500);
		drain();
		// zero acts as one
		write_length(11'd0);
		send_sample(22'h3FFFFF);
		send_sample(22'd0);
		send_sample(22'd999);
		send_sample(22'd1000);
		drain();
		write_length(11'd2);
		send_sample(22'd5);
		send_sample(22'd5);
		send_sample(22'd7);
		send_sample(22'd3);
		send_sample(22'd3);
		send_sample(22'd7);
		drain();
		// repeated extremes keep the first position
		write_length(11'd3);
		send_sample(22'h3FFFFF);
		send_sample(22'd0);
		send_sample(22'h3FFFFF);
		send_sample(22'd2000);
		send_sample(22'd2000);
		send_sample(22'd1000);
		drain();
		directed_count = board.samples_noted;

		phase = 0;
		while (board.samples_noted - directed_count < 1030) begin
			// the full-length window runs with no idling on either side
			idling_on = (phase != 2);
			if (phase == 2) begin
				// full-length window, mostly full scale, finished under an over-range length
				write_length(wprm_pkg::MAX_WINDOW);
				repeat (700)
					send_sample(($urandom_range(0, 3) != 0) ? 22'h3FFFFF : pick_sample());
				drain();
				write_length(11'h7FF);
				do
					send_sample(pick_sample());
				while (board.position != 0);
				drain();
			end else begin
				case ($urandom_range(0, 9))
					0:       next_length = '0;
					1:       next_length = wprm_pkg::LEN_W'($urandom_range(13, 40));
					default: next_length = wprm_pkg::LEN_W'($urandom_range(1, 12));
				endcase
				write_length(next_length);
				burst_len = $urandom_range(10, 60);
				repeat (burst_len)
					send_sample(pick_sample());
				drain();
			end
			phase++;
		end

		idling_on = 1'b1;
		drain();
		$display("Sent %0d samples, checked %0d readings over %0d window lengths",
			board.samples_noted, board.readings_checked, settings_used);
		$display("Lengths included 0, 1, 1024 and 2047, with mid-window length changes.");
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
